/* rtl/dotl_pkg.sv */
package dotl_pkg;

  // Data widths of the item fields.
  localparam int unsigned TARGET_W = 15;
  localparam int unsigned MEAS_W   = 16;
  localparam int unsigned SP_W     = 16;
  localparam int unsigned CODE_W   = 12;
  localparam int unsigned TOL_W    = 10;

  // Wide enough for measured minus target and for the moved setpoint.
  localparam int unsigned DIFF_W = 18;

  // Configuration port.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_TOLERANCE = 2'd0;

  localparam logic [TOL_W-1:0] TOLERANCE_RESET = 10'd5;

  // Default number of trim attempts.
  localparam int unsigned MAX_TRIES = 50;

  // Request codes.
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_MEASURE = 1'b1;

  // Limits of the trim loop, in mV.
  localparam logic signed [DIFF_W-1:0] WINDOW_MV     = 18'sd200;
  localparam logic [TARGET_W-1:0]      MIN_TARGET_MV = 15'd50;

  // code = floor(s * 2048 / 9405) is taken as (s * CODE_MUL) >> CODE_SHIFT.
  // CODE_MUL is 2^39 / 9405 rounded up; the error stays below one part in
  // 9405 over the whole 15-bit setpoint range, so the quotient is exact.
  localparam int unsigned CODE_MUL_W = 26;
  localparam logic [CODE_MUL_W-1:0] CODE_MUL = 26'd58453569;
  localparam int unsigned CODE_SHIFT = 28;
  localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;

endpackage

/* rtl/dac_output_trim_loop.sv */
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_ready_o   req_type_i, target_mv_i, measured_mv_i
// result    out        out_valid_o/out_ready_i dac_code_o, done_res_o, fail_o
// config    in         APB psel/penable/pready tolerance_mv at byte address 0
//
// One item is taken per clock cycle unless a stalled result has filled the
// stages; each result passes through the three register stages (input,
// trim state, code) before it is offered.
// Reset clears the trim state, the stage valid flags and sets the tolerance
// to 5 mV; no clearing pass is needed.
// A stalled result only holds the stages behind it that are full, so empty
// stages keep taking items until the pipeline is full.

module dac_output_trim_loop #(
  parameter int unsigned MaxTries = dotl_pkg::MAX_TRIES
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   req_type_i,
  input  logic        [dotl_pkg::TARGET_W-1:0]   target_mv_i,
  input  logic signed [dotl_pkg::MEAS_W-1:0]     measured_mv_i,

  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic        [dotl_pkg::CODE_W-1:0]     dac_code_o,
  output logic                                   done_res_o,
  output logic                                   fail_o,

  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [dotl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic        [dotl_pkg::APB_DATA_W-1:0] pwdata,
  output logic        [dotl_pkg::APB_DATA_W-1:0] prdata,
  output logic                                   pready
);

  localparam int unsigned TriesW = $clog2(MaxTries + 1);
  localparam logic [TriesW-1:0] TriesInit = TriesW'(MaxTries);

  // Phase of the trim run.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_TRIM  = 2'd2;

  localparam int unsigned DW = dotl_pkg::DIFF_W;
  localparam int unsigned SW = dotl_pkg::SP_W;

  // ---------------------------------------------------------------------------
  // Configuration register. Writes complete in the access phase; pready is
  // tied high, so no transfer is extended by wait states.
  // ---------------------------------------------------------------------------
  logic [dotl_pkg::TOL_W-1:0] tol_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= dotl_pkg::TOLERANCE_RESET;
    end else if (psel && penable && pwrite && (paddr == dotl_pkg::ADDR_TOLERANCE)) begin
      tol_q <= pwdata[dotl_pkg::TOL_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      dotl_pkg::ADDR_TOLERANCE: prdata = dotl_pkg::APB_DATA_W'(tol_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage handshake. A stage moves on when it is empty or the stage after it
  // moves on, so bubbles close up behind a stalled result.
  // ---------------------------------------------------------------------------
  logic s0_valid_q, s1_valid_q, s2_valid_q;
  logic s0_ready, s1_ready, s2_ready;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s0_ready   = !s0_valid_q || s1_ready;
  assign in_ready_o = s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_q <= in_valid_i;
      end
      if (s1_ready) begin
        s1_valid_q <= s0_valid_q;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register.
  // ---------------------------------------------------------------------------
  logic                                 s0_req_q;
  logic        [dotl_pkg::TARGET_W-1:0] s0_tgt_q;
  logic signed [dotl_pkg::MEAS_W-1:0]   s0_meas_q;

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i) begin
      s0_req_q  <= req_type_i;
      s0_tgt_q  <= target_mv_i;
      s0_meas_q <= measured_mv_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: trim state update. The run state changes only when an item
  // leaves stage 0, so each item sees the state left by the one before it.
  // ---------------------------------------------------------------------------
  logic        [1:0]                    phase_q, phase_d;
  logic signed [SW-1:0]                 sp_q, sp_d;
  logic        [dotl_pkg::TARGET_W-1:0] tgt_hold_q, tgt_hold_d;
  logic        [TriesW-1:0]             tries_q, tries_d;
  logic                                 done_d, fail_d;
  logic                                 step_en;

  logic signed [DW-1:0] diff;       // measured minus target
  logic signed [DW-1:0] tol_s;
  logic signed [DW-1:0] sp_moved;
  logic signed [SW-1:0] sp_sat;
  logic                 in_window;
  logic                 in_tol;

  assign step_en = s0_valid_q && s1_ready;

  assign diff  = DW'(s0_meas_q) - $signed({{(DW - dotl_pkg::TARGET_W){1'b0}}, tgt_hold_q});
  assign tol_s = $signed({{(DW - dotl_pkg::TOL_W){1'b0}}, tol_q});

  assign in_window = (diff > -dotl_pkg::WINDOW_MV) && (diff < dotl_pkg::WINDOW_MV);
  assign in_tol    = (diff > -tol_s) && (diff < tol_s);

  // New setpoint is the old one less the error, clamped to 16-bit signed.
  assign sp_moved = DW'(sp_q) - diff;

  always_comb begin
    if (sp_moved > $signed(DW'({1'b0, {(SW - 1){1'b1}}}))) begin
      sp_sat = {1'b0, {(SW - 1){1'b1}}};
    end else if (sp_moved < -DW'($signed({1'b0, 1'b1, {(SW - 1){1'b0}}}))) begin
      sp_sat = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      sp_sat = sp_moved[SW-1:0];
    end
  end

  always_comb begin
    phase_d    = phase_q;
    sp_d       = sp_q;
    tgt_hold_d = tgt_hold_q;
    tries_d    = tries_q;
    done_d     = 1'b0;
    fail_d     = 1'b0;

    if (s0_req_q == dotl_pkg::REQ_START) begin
      // A start abandons any run in progress.
      tgt_hold_d = s0_tgt_q;
      sp_d       = $signed({1'b0, s0_tgt_q});
      phase_d    = PH_FIRST;
    end else begin
      unique case (phase_q)
        PH_FIRST: begin
          if (tgt_hold_q < dotl_pkg::MIN_TARGET_MV) begin
            done_d = 1'b1;
          end else if (!in_window) begin
            done_d = 1'b1;
            fail_d = 1'b1;
          end else begin
            tries_d = TriesInit;
            sp_d    = sp_sat;
            phase_d = PH_TRIM;
          end
        end
        PH_TRIM: begin
          if (in_tol) begin
            done_d = 1'b1;
          end else begin
            tries_d = tries_q - TriesW'(1);
            if (tries_q == TriesW'(1)) begin
              // Last attempt used up: the setpoint stays where it is.
              done_d = 1'b1;
              fail_d = 1'b1;
            end else begin
              sp_d = sp_sat;
            end
          end
        end
        default: begin
          // Idle: a measurement is answered with the current code only.
        end
      endcase
    end

    if (done_d) begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      sp_q       <= '0;
      tgt_hold_q <= '0;
      tries_q    <= '0;
    end else if (step_en) begin
      phase_q    <= phase_d;
      sp_q       <= sp_d;
      tgt_hold_q <= tgt_hold_d;
      tries_q    <= tries_d;
    end
  end

  logic signed [SW-1:0] s1_sp_q;
  logic                 s1_done_q, s1_fail_q;

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      s1_sp_q   <= sp_d;
      s1_done_q <= done_d;
      s1_fail_q <= fail_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: DAC code of the setpoint, held in the result register.
  // ---------------------------------------------------------------------------
  logic [dotl_pkg::CODE_W-1:0] code;
  logic [dotl_pkg::CODE_W-1:0] s2_code_q;
  logic                        s2_done_q, s2_fail_q;

  dotl_code u_code (
    .setpoint_i (s1_sp_q),
    .code_o     (code)
  );

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_code_q <= code;
      s2_done_q <= s1_done_q;
      s2_fail_q <= s1_fail_q;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign dac_code_o  = s2_code_q;
  assign done_res_o  = s2_done_q;
  assign fail_o      = s2_fail_q;

endmodule

/* rtl/dotl_code.sv */
module dotl_code (
  input  logic signed [dotl_pkg::SP_W-1:0]   setpoint_i,
  output logic        [dotl_pkg::CODE_W-1:0] code_o
);

  localparam int unsigned MagW  = dotl_pkg::SP_W - 1;
  localparam int unsigned ProdW = MagW + dotl_pkg::CODE_MUL_W;
  localparam int unsigned QuotW = ProdW - dotl_pkg::CODE_SHIFT;

  logic [MagW-1:0]  mag;
  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot;

  assign mag  = setpoint_i[MagW-1:0];
  assign prod = ProdW'(mag) * ProdW'(dotl_pkg::CODE_MUL);
  assign quot = prod[ProdW-1:dotl_pkg::CODE_SHIFT];

  // Zero and negative setpoints give code zero; the top of the range saturates.
  always_comb begin
    if (setpoint_i[dotl_pkg::SP_W-1] || (mag == '0)) begin
      code_o = '0;
    end else if (quot > QuotW'(dotl_pkg::CODE_MAX)) begin
      code_o = dotl_pkg::CODE_MAX;
    end else begin
      code_o = quot[dotl_pkg::CODE_W-1:0];
    end
  end

endmodule

/* rtl/dotl_checker.sv */
module dotl_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic        [dotl_pkg::CODE_W-1:0]     dac_code_o,
  input logic                                   done_res_o,
  input logic                                   fail_o,
  input logic        [dotl_pkg::APB_DATA_W-1:0] prdata
);

  // Items taken but not yet delivered; the block holds at most three.
  logic [2:0] pending_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_fail_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fail_o |-> done_res_o)
    else $error("fail shown without done");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result shown with no item outstanding");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more items outstanding than the pipeline holds");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dac_code_o)
      && $stable(done_res_o) && $stable(fail_o))
    else $error("stalled result changed");

  a_prdata_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[dotl_pkg::APB_DATA_W-1:dotl_pkg::TOL_W] == '0)
    else $error("read data has bits above the tolerance field");

endmodule

bind dac_output_trim_loop dotl_checker u_dotl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .dac_code_o  (dac_code_o),
  .done_res_o  (done_res_o),
  .fail_o      (fail_o),
  .prdata      (prdata)
);

/* bench/dac_output_trim_loop_tb.sv */
`timescale 1ns / 1ps

typedef enum logic [1:0] {
  TRIM_IDLE,
  TRIM_AWAIT_FIRST,
  TRIM_ACTIVE
} trim_phase_e;

typedef struct packed {
  logic [dotl_pkg::CODE_W-1:0] dac_code;
  logic                        done_res;
  logic                        fail;
} trim_result_t;

class trim_board;
  // Mirror of the block's trim state and its tolerance register.
  trim_phase_e                   phase;
  logic signed [dotl_pkg::SP_W-1:0] setpoint;
  logic [dotl_pkg::TARGET_W-1:0] target;
  logic [5:0]                    tries_left;
  logic [dotl_pkg::TOL_W-1:0]    tolerance;
  trim_result_t                  pending_results[$];
  int                            errors;

  function new();
    phase      = TRIM_IDLE;
    setpoint   = '0;
    target     = '0;
    tries_left = '0;
    tolerance  = dotl_pkg::TOLERANCE_RESET;
    errors     = 0;
  endfunction

  function void set_tolerance(logic [dotl_pkg::TOL_W-1:0] value);
    tolerance = value;
  endfunction

  function bit busy();
    return phase != TRIM_IDLE;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // Moves the setpoint against the error, clamped to the 16-bit signed range.
  function void pull_setpoint(int meas);
    int moved;
    moved = int'(setpoint) - (meas - int'(target));
    if (moved > 32767) moved = 32767;
    if (moved < -32768) moved = -32768;
    setpoint = moved[dotl_pkg::SP_W-1:0];
  endfunction

  function logic [dotl_pkg::CODE_W-1:0] code_for_setpoint();
    longint scaled;
    if (setpoint <= 0) return '0;
    scaled = (longint'(setpoint) * 2048) / 9405;
    if (scaled > 4095) scaled = 4095;
    return scaled[dotl_pkg::CODE_W-1:0];
  endfunction

  function void take_transfer(logic req, logic [dotl_pkg::TARGET_W-1:0] tgt,
                              logic signed [dotl_pkg::MEAS_W-1:0] meas);
    int           m;
    int           t;
    int           tol;
    trim_result_t r;
    m = int'(meas);
    t = int'(target);
    tol = int'(tolerance);
    r = '0;
    if (req == dotl_pkg::REQ_START) begin
      target   = tgt;
      setpoint = {1'b0, tgt};
      phase    = TRIM_AWAIT_FIRST;
    end else if (phase == TRIM_AWAIT_FIRST) begin
      if (t < 50) begin
        r.done_res = 1'b1;
      end else if (!(m > t - 200 && m < t + 200)) begin
        r.done_res = 1'b1;
        r.fail     = 1'b1;
      end else begin
        tries_left = 6'(dotl_pkg::MAX_TRIES);
        pull_setpoint(m);
        phase = TRIM_ACTIVE;
      end
    end else if (phase == TRIM_ACTIVE) begin
      if (m > t - tol && m < t + tol) begin
        r.done_res = 1'b1;
      end else begin
        tries_left = tries_left - 6'd1;
        if (tries_left == 6'd0) begin
          r.done_res = 1'b1;
          r.fail     = 1'b1;
        end else begin
          pull_setpoint(m);
        end
      end
    end
    if (r.done_res) phase = TRIM_IDLE;
    r.dac_code = code_for_setpoint();
    pending_results.push_back(r);
  endfunction

  function void check_result(logic [dotl_pkg::CODE_W-1:0] code, logic done, logic failed);
    trim_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result code %0d done %0d fail %0d", $time, code, done, failed);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (code !== want.dac_code) begin
      $display("%0t: dac_code expected %0d, got %0d", $time, want.dac_code, code);
      errors++;
    end
    if (done !== want.done_res) begin
      $display("%0t: done_res expected %0d, got %0d", $time, want.done_res, done);
      errors++;
    end
    if (failed !== want.fail) begin
      $display("%0t: fail expected %0d, got %0d", $time, want.fail, failed);
      errors++;
    end
  endfunction

  function void check_readback(logic [dotl_pkg::APB_DATA_W-1:0] value);
    if (value !== {{(dotl_pkg::APB_DATA_W-dotl_pkg::TOL_W){1'b0}}, tolerance}) begin
      $display("%0t: tolerance_mv readback expected %0d, got %0d", $time, tolerance, value);
      errors++;
    end
  endfunction
endclass

module dac_output_trim_loop_tb;

  // This limit leaves a wide margin over the slowest correct run before the
  // run is declared hung.
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Depth of the block: three register stages between transfer and result.
  localparam int unsigned PIPE_DEPTH = 3;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  in_valid_i;
  logic                                  in_ready_o;
  logic                                  req_type_i;
  logic        [dotl_pkg::TARGET_W-1:0]   target_mv_i;
  logic signed [dotl_pkg::MEAS_W-1:0]     measured_mv_i;
  logic                                  out_valid_o;
  logic                                  out_ready_i;
  logic        [dotl_pkg::CODE_W-1:0]     dac_code_o;
  logic                                  done_res_o;
  logic                                  fail_o;
  logic                                  psel;
  logic                                  penable;
  logic                                  pwrite;
  logic        [dotl_pkg::APB_ADDR_W-1:0] paddr;
  logic        [dotl_pkg::APB_DATA_W-1:0] pwdata;
  logic        [dotl_pkg::APB_DATA_W-1:0] prdata;
  logic                                  pready;

  trim_board   board;
  int unsigned cycle_count;
  int          items_sent;
  // Cleared for the final stretch, so that the last part of the run streams
  // back to back on both channels.
  bit          idling_on;

  dac_output_trim_loop u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .target_mv_i   (target_mv_i),
    .measured_mv_i (measured_mv_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .dac_code_o    (dac_code_o),
    .done_res_o    (done_res_o),
    .fail_o        (fail_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a run that stops making progress ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("dac_output_trim_loop regression: fail");
      $finish;
    end
  end

  // Results are sampled at the clock edge, so the values seen are those that
  // were present just before it, whatever order the processes run in.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(dac_code_o, done_res_o, fail_o);
    end
  end

  // The result side stalls in random bursts, separated by runs of
  // readiness, and stays ready throughout once idling is off.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (idling_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Offers one item and waits for its transfer. Valid is left high on
  // return, so a following item is offered on the very next cycle unless a
  // gap is drawn; a gap lowers valid in a step of its own.
  task automatic send_item(input logic req, input logic [dotl_pkg::TARGET_W-1:0] tgt,
                           input logic signed [dotl_pkg::MEAS_W-1:0] meas);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    target_mv_i   <= tgt;
    measured_mv_i <= meas;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_transfer(req, tgt, meas);
    items_sent++;
  endtask

  task automatic send_start(input int tgt);
    send_item(dotl_pkg::REQ_START, tgt[dotl_pkg::TARGET_W-1:0], 16'sd0 + 16'($urandom));
  endtask

  task automatic send_reading(input int mv);
    send_item(dotl_pkg::REQ_MEASURE, 15'($urandom), mv[dotl_pkg::MEAS_W-1:0]);
  endtask

  // Lowers valid and waits for the pipeline to drain, so that a register
  // write lands while the block holds no item.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 1) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // edge that closes the access cycle. The value is then read back.
  task automatic set_tolerance(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dotl_pkg::ADDR_TOLERANCE;
    pwdata  <= dotl_pkg::APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    board.set_tolerance(value[dotl_pkg::TOL_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    read_tolerance();
  endtask

  task automatic read_tolerance;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= dotl_pkg::ADDR_TOLERANCE;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    board.check_readback(prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Picks a reading that misses the tolerance band around the target.
  function automatic int missing_reading(input int tgt, input int tol);
    int offset;
    offset = tol + $urandom_range(0, 300);
    return ($urandom_range(0, 1) == 0) ? tgt - offset : tgt + offset;
  endfunction

  // One trim run: a start, a first reading that usually opens the window,
  // and a train of readings until the run ends. Long runs nearly always
  // miss, so that the retry budget is used up. A few runs are abandoned
  // by the next start, and now and then a reading is sent while idle.
  task automatic trim_run;
    int tgt;
    int tol;
    int count;
    int mv;
    bit long_run;
    tol = int'(board.tolerance);
    case ($urandom_range(0, 9))
      0: tgt = $urandom_range(0, 49);
      1: begin
        case ($urandom_range(0, 3))
          0: tgt = 50;
          1: tgt = 20000;
          2: tgt = 16384;
          default: tgt = 49;
        endcase
      end
      default: tgt = $urandom_range(50, 20000);
    endcase
    send_start(tgt);
    if ($urandom_range(0, 19) == 0) return;

    case ($urandom_range(0, 9))
      8: mv = ($urandom_range(0, 1) == 0) ? tgt - 200 : tgt + 200;
      9: mv = int'($signed(16'($urandom)));
      default: mv = tgt + $urandom_range(0, 398) - 199;
    endcase
    send_reading(mv);

    long_run = ($urandom_range(0, 7) == 0);
    count = long_run ? $urandom_range(50, 56) : $urandom_range(1, 15);
    while (count > 0 && board.busy()) begin
      if (!long_run && $urandom_range(0, 4) == 0) begin
        mv = (tol == 0) ? tgt : tgt + $urandom_range(0, 2 * tol - 2) - (tol - 1);
      end else begin
        case ($urandom_range(0, 7))
          6: mv = ($urandom_range(0, 1) == 0) ? tgt - tol : tgt + tol;
          7: mv = int'($signed(16'($urandom)));
          default: mv = missing_reading(tgt, tol);
        endcase
      end
      send_reading(mv);
      count--;
    end
    if (!board.busy() && $urandom_range(0, 9) == 0) send_reading(int'($signed(16'($urandom))));
  endtask

  task automatic trim_phase(input int quota);
    int stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) trim_run();
  endtask

  initial begin
    board         = new();
    cycle_count   = 0;
    items_sent    = 0;
    idling_on     = 1'b1;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = dotl_pkg::REQ_START;
    target_mv_i   = '0;
    measured_mv_i = '0;
    out_ready_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The register must come out of reset at 5 mV.
    read_tolerance();
    @(posedge clk_i);

    // Directed part, at the reset tolerance. A reading while idle answers
    // with the code of the zero setpoint.
    send_reading(0);
    // Targets under 50 mV pass on any first reading.
    send_start(0);
    send_reading(-32768);
    send_start(49);
    send_reading(32767);
    // The largest target saturates the code; a reading on the window edge
    // fails the run.
    send_start(20000);
    send_reading(20200);
    send_start(1000);
    send_reading(800);
    // A trim that misses on both tolerance edges before passing.
    send_start(1000);
    send_reading(1199);
    send_reading(995);
    send_reading(1005);
    send_reading(1004);
    // The smallest target that is checked against the window.
    send_start(50);
    send_reading(32767);
    // Setpoint pushed into positive saturation, then the run is abandoned
    // by a fresh start.
    send_start(20000);
    send_reading(19801);
    send_reading(-32768);
    send_start(3000);
    send_reading(3000);
    send_reading(3000);
    // Setpoint driven into negative saturation: the code clamps to zero.
    send_start(300);
    send_reading(101);
    send_reading(32767);
    send_reading(32767);
    send_reading(300);
    send_reading(5);

    // Random part, over tolerances from zero up to 1000. A zero tolerance
    // can never be met, so no trim there ends by meeting the tolerance.
    drain();
    set_tolerance(0);
    trim_phase(240);
    drain();
    set_tolerance(1000);
    trim_phase(240);
    drain();
    set_tolerance(1);
    trim_phase(240);
    drain();
    set_tolerance(999);
    trim_phase(240);
    drain();
    set_tolerance($urandom_range(2, 998));
    trim_phase(240);
    drain();
    set_tolerance($urandom_range(2, 60));
    trim_phase(240);
    drain();
    set_tolerance(5);
    @(posedge clk_i);
    idling_on = 1'b0;
    trim_phase(240);

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("dac_output_trim_loop regression: pass");
    end else begin
      $display("dac_output_trim_loop regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dotl_pkg.sv
rtl/dotl_code.sv
rtl/dac_output_trim_loop.sv
rtl/dotl_checker.sv
bench/dac_output_trim_loop_tb.sv
